// ----- design/drnm_pkg.sv -----
// shared constants and types for the delta-r nearest match block
`timescale 1ns / 1ps

package drnm_pkg;

  // parameter defaults
  localparam int unsigned MAX_CANDIDATES_DEF = 64;
  localparam int unsigned ANGLE_BITS_DEF     = 13;

  // field widths
  localparam int unsigned ETA_W    = 14;
  localparam int unsigned PHI_W    = 13;
  localparam int unsigned DIST_W   = 29;
  localparam int unsigned IDX_W    = 7;

  // squared terms: |deta| needs 15 bits, |dphi| at most 14 bits
  localparam int unsigned ETA_SQ_W = 30;
  localparam int unsigned PHI_SQ_W = 28;

  localparam logic [DIST_W-1:0] DIST_MAX   = {DIST_W{1'b1}};
  localparam logic [DIST_W-1:0] CFG_RESET  = 29'd272484;
  localparam logic [IDX_W-1:0]  NO_MATCH   = {IDX_W{1'b1}};

  // word passed from the distance stage to the tracker
  typedef struct packed {
    logic                list_end;
    logic                no_cand;
    logic [ETA_SQ_W-1:0] eta_sq;
    logic [PHI_SQ_W-1:0] phi_sq;
  } sq_word_t;

endpackage

// ----- design/drnm_dist.sv -----
// input register and squared eta/phi difference stage
`timescale 1ns / 1ps

module drnm_dist #(
  parameter int unsigned ANGLE_BITS = drnm_pkg::ANGLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [drnm_pkg::ETA_W-1:0]  in_ref_eta,
  input  logic signed [drnm_pkg::PHI_W-1:0]  in_ref_phi,
  input  logic signed [drnm_pkg::ETA_W-1:0]  in_cand_eta,
  input  logic signed [drnm_pkg::PHI_W-1:0]  in_cand_phi,
  input  logic                               in_list_end,
  input  logic                               in_no_candidates,
  output logic                               sq_valid,
  output drnm_pkg::sq_word_t                 sq_word,
  input  logic                               sq_ready
);

  localparam int unsigned DPHI_W = drnm_pkg::PHI_W + 1;
  localparam int unsigned DETA_W = drnm_pkg::ETA_W + 1;

  logic                             v1_r;
  logic                             v2_r;
  logic [drnm_pkg::ETA_W-1:0]       ref_eta_r;
  logic [drnm_pkg::PHI_W-1:0]       ref_phi_r;
  logic [drnm_pkg::ETA_W-1:0]       cand_eta_r;
  logic [drnm_pkg::PHI_W-1:0]       cand_phi_r;
  logic                             list_end_r;
  logic                             no_cand_r;
  drnm_pkg::sq_word_t               word_r;
  drnm_pkg::sq_word_t               word_nxt;

  logic                             adv1;
  logic                             adv2;
  logic [DETA_W-1:0]                deta;
  logic [DETA_W-1:0]                deta_abs;
  logic [DPHI_W-1:0]                dphi_raw;
  logic [DPHI_W-1:0]                dphi;
  logic [DPHI_W-1:0]                dphi_abs;

  assign adv2     = !v2_r || sq_ready;
  assign adv1     = !v1_r || adv2;
  assign in_ready = adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (adv1) begin
        v1_r <= in_valid;
      end
      if (adv2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      ref_eta_r  <= in_ref_eta;
      ref_phi_r  <= in_ref_phi;
      cand_eta_r <= in_cand_eta;
      cand_phi_r <= in_cand_phi;
      list_end_r <= in_list_end;
      no_cand_r  <= in_no_candidates;
    end
    if (adv2 && v1_r) begin
      word_r <= word_nxt;
    end
  end

  // differences, sign extended by one bit so they cannot overflow
  assign deta     = {ref_eta_r[drnm_pkg::ETA_W-1], ref_eta_r}
                  - {cand_eta_r[drnm_pkg::ETA_W-1], cand_eta_r};
  assign dphi_raw = {ref_phi_r[drnm_pkg::PHI_W-1], ref_phi_r}
                  - {cand_phi_r[drnm_pkg::PHI_W-1], cand_phi_r};

  // phi wraps to [-pi, pi) by keeping ANGLE_BITS bits
  generate
    if (ANGLE_BITS >= DPHI_W) begin : g_nowrap
      assign dphi = dphi_raw;
    end else begin : g_wrap
      assign dphi = {{(DPHI_W - ANGLE_BITS){dphi_raw[ANGLE_BITS-1]}},
                     dphi_raw[ANGLE_BITS-1:0]};
    end
  endgenerate

  assign deta_abs = deta[DETA_W-1] ? (~deta + 1'b1) : deta;
  assign dphi_abs = dphi[DPHI_W-1] ? (~dphi + 1'b1) : dphi;

  always_comb begin
    word_nxt.list_end = list_end_r;
    word_nxt.no_cand  = no_cand_r;
    word_nxt.eta_sq   = drnm_pkg::ETA_SQ_W'(deta_abs) * drnm_pkg::ETA_SQ_W'(deta_abs);
    word_nxt.phi_sq   = drnm_pkg::PHI_SQ_W'(dphi_abs) * drnm_pkg::PHI_SQ_W'(dphi_abs);
  end

  assign sq_valid = v2_r;
  assign sq_word  = word_r;

endmodule

// ----- design/drnm_track.sv -----
// running minimum tracker and result register
`timescale 1ns / 1ps

module drnm_track #(
  parameter int unsigned MAX_CANDIDATES = drnm_pkg::MAX_CANDIDATES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [drnm_pkg::DIST_W-1:0]        max_dr_squared,
  input  logic                               sq_valid,
  input  drnm_pkg::sq_word_t                 sq_word,
  output logic                               sq_ready,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_matched,
  output logic signed [drnm_pkg::IDX_W-1:0]  out_match_index,
  output logic [drnm_pkg::DIST_W-1:0]        out_best_dist_squared,
  output logic                               out_overflow
);

  localparam int unsigned CW  = $clog2(MAX_CANDIDATES + 1);
  localparam int unsigned IW  = $clog2(MAX_CANDIDATES);
  localparam int unsigned IXW = (IW > drnm_pkg::IDX_W) ? IW : drnm_pkg::IDX_W;
  localparam int unsigned SW  = drnm_pkg::ETA_SQ_W + 1;

  logic [drnm_pkg::DIST_W-1:0] best_r,  best_nxt;
  logic [IW-1:0]               idx_r,   idx_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic                        ovf_r,   ovf_nxt;
  logic                        out_valid_r;
  logic                        matched_r, matched_nxt;
  logic [drnm_pkg::IDX_W-1:0]  index_r,   index_nxt;
  logic [drnm_pkg::DIST_W-1:0] dist_out_r, dist_out_nxt;
  logic                        ovf_out_r,  ovf_out_nxt;

  logic                        produces;
  logic                        slot_free;
  logic                        take;
  logic [SW-1:0]               sum;
  logic [drnm_pkg::DIST_W-1:0] cand_dsq;
  logic [IXW-1:0]              idx_wide;
  logic                        hit;

  assign produces  = sq_word.no_cand || sq_word.list_end;
  assign slot_free = !out_valid_r || out_ready;
  assign sq_ready  = !produces || slot_free;
  assign take      = sq_valid && sq_ready;

  // squared distance, saturated to the field width
  assign sum      = SW'(sq_word.eta_sq) + SW'(sq_word.phi_sq);
  assign cand_dsq = (sum > SW'(drnm_pkg::DIST_MAX)) ? drnm_pkg::DIST_MAX
                                                    : sum[drnm_pkg::DIST_W-1:0];

  always_comb begin
    best_nxt     = best_r;
    idx_nxt      = idx_r;
    count_nxt    = count_r;
    ovf_nxt      = ovf_r;
    matched_nxt  = 1'b0;
    index_nxt    = drnm_pkg::NO_MATCH;
    dist_out_nxt = drnm_pkg::DIST_MAX;
    ovf_out_nxt  = 1'b0;
    idx_wide     = '0;
    hit          = 1'b0;
    if (sq_word.no_cand) begin
      best_nxt  = drnm_pkg::DIST_MAX;
      idx_nxt   = '0;
      count_nxt = '0;
      ovf_nxt   = 1'b0;
    end else begin
      if (count_r < CW'(MAX_CANDIDATES)) begin
        // first candidate always wins, later ones only when strictly closer
        if (count_r == '0 || cand_dsq < best_r) begin
          best_nxt = cand_dsq;
          idx_nxt  = count_r[IW-1:0];
        end
        count_nxt = count_r + 1'b1;
      end else begin
        ovf_nxt = 1'b1;
      end
      if (sq_word.list_end) begin
        hit          = best_nxt < max_dr_squared;
        idx_wide     = IXW'(idx_nxt);
        matched_nxt  = hit;
        index_nxt    = hit ? idx_wide[drnm_pkg::IDX_W-1:0] : drnm_pkg::NO_MATCH;
        dist_out_nxt = best_nxt;
        ovf_out_nxt  = ovf_nxt;
        best_nxt     = drnm_pkg::DIST_MAX;
        idx_nxt      = '0;
        count_nxt    = '0;
        ovf_nxt      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r      <= drnm_pkg::DIST_MAX;
      idx_r       <= '0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        best_r  <= best_nxt;
        idx_r   <= idx_nxt;
        count_r <= count_nxt;
        ovf_r   <= ovf_nxt;
      end
      if (take && produces) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && produces) begin
      matched_r  <= matched_nxt;
      index_r    <= index_nxt;
      dist_out_r <= dist_out_nxt;
      ovf_out_r  <= ovf_out_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_matched           = matched_r;
  assign out_match_index       = index_r;
  assign out_best_dist_squared = dist_out_r;
  assign out_overflow          = ovf_out_r;

endmodule

// ----- design/delta_r_nearest_match.sv -----
// top level of the delta-r nearest match block
`timescale 1ns / 1ps

// Matches one reference object against a streamed list of candidates by
// smallest squared distance deta^2 + dphi^2 (angle LSB pi/4096, phi wrapped
// to [-pi, pi)). One word per candidate, list_end on the last; a word with
// no_candidates closes an empty list at once. One result word per list:
// matched is set when the smallest distance is strictly below
// max_dr_squared, match_index then gives the candidate's place in the list
// (first one wins a tie), else -1. Candidates past MAX_CANDIDATES are not
// compared and raise overflow. Throughput is one word per clock unless a
// result is held back; a closing word's result passes the input register,
// square stage and tracker/result register before it is offered. Only a
// list-closing word waits for the result register, so back-pressure on the
// output stalls the input only when a second result is due. Write cfg_wdata
// only while the block is idle.

module delta_r_nearest_match #(
  parameter int unsigned MAX_CANDIDATES = drnm_pkg::MAX_CANDIDATES_DEF,
  parameter int unsigned ANGLE_BITS     = drnm_pkg::ANGLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration: squared matching radius
  input  logic                               cfg_we,
  input  logic [drnm_pkg::DIST_W-1:0]        cfg_wdata,
  // candidate words
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [drnm_pkg::ETA_W-1:0]  in_ref_eta,
  input  logic signed [drnm_pkg::PHI_W-1:0]  in_ref_phi,
  input  logic signed [drnm_pkg::ETA_W-1:0]  in_cand_eta,
  input  logic signed [drnm_pkg::PHI_W-1:0]  in_cand_phi,
  input  logic                               in_list_end,
  input  logic                               in_no_candidates,
  // result words
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_matched,
  output logic signed [drnm_pkg::IDX_W-1:0]  out_match_index,
  output logic [drnm_pkg::DIST_W-1:0]        out_best_dist_squared,
  output logic                               out_overflow
);

  logic [drnm_pkg::DIST_W-1:0] max_dr_r;
  logic                        sq_valid;
  logic                        sq_ready;
  drnm_pkg::sq_word_t          sq_word;

  // radius register, strict less-than test downstream
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_dr_r <= drnm_pkg::CFG_RESET;
    end else if (cfg_we) begin
      max_dr_r <= cfg_wdata;
    end
  end

  // input register plus squared differences
  drnm_dist #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_dist (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_ref_eta       (in_ref_eta),
    .in_ref_phi       (in_ref_phi),
    .in_cand_eta      (in_cand_eta),
    .in_cand_phi      (in_cand_phi),
    .in_list_end      (in_list_end),
    .in_no_candidates (in_no_candidates),
    .sq_valid         (sq_valid),
    .sq_word          (sq_word),
    .sq_ready         (sq_ready)
  );

  // running minimum and result register
  drnm_track #(
    .MAX_CANDIDATES (MAX_CANDIDATES)
  ) u_track (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .max_dr_squared        (max_dr_r),
    .sq_valid              (sq_valid),
    .sq_word               (sq_word),
    .sq_ready              (sq_ready),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_matched           (out_matched),
    .out_match_index       (out_match_index),
    .out_best_dist_squared (out_best_dist_squared),
    .out_overflow          (out_overflow)
  );

endmodule

// ----- tb/delta_r_nearest_match_tb.sv -----
// testbench for delta_r_nearest_match: directed and random candidate lists checked by a scoreboard
`timescale 1ns / 1ps

module delta_r_nearest_match_tb;

  localparam int unsigned MAX_CAND    = drnm_pkg::MAX_CANDIDATES_DEF;
  localparam int unsigned ANG_BITS    = drnm_pkg::ANGLE_BITS_DEF;
  localparam int          PHASES      = 6;
  localparam int          PHASE_WORDS = 255;   // random words per radius setting
  localparam int          SETTLE      = 8;     // pipeline is three deep, leave some slack
  localparam int          LONG_HOLD   = 300;   // receiver hold-off, fills the block
  localparam int          STALL_LIMIT = 4000;  // cycles with no handshake before giving up

  // one candidate word as offered on the input channel
  typedef struct {
    logic signed [drnm_pkg::ETA_W-1:0] r_eta;
    logic signed [drnm_pkg::PHI_W-1:0] r_phi;
    logic signed [drnm_pkg::ETA_W-1:0] c_eta;
    logic signed [drnm_pkg::PHI_W-1:0] c_phi;
    logic                              list_end;
    logic                              no_cand;
  } cand_word_t;

  // one result word
  typedef struct {
    logic                              matched;
    logic signed [drnm_pkg::IDX_W-1:0] idx;
    logic [drnm_pkg::DIST_W-1:0]       best_dsq;
    logic                              ovf;
  } match_word_t;

  // receiver back-pressure patterns
  typedef enum int {
    RX_FREE,
    RX_HALF,
    RX_SPARSE,
    RX_PERIODIC,
    RX_BLOCKED
  } rx_mode_t;

  // nearest-match predictor plus the queue of result words still owed
  class match_scoreboard;
    logic [drnm_pkg::DIST_W-1:0] radius_sq;
    logic [drnm_pkg::DIST_W-1:0] best_dsq;
    int unsigned                 best_pos;
    int unsigned                 seen_cnt;
    bit                          ovf_seen;
    match_word_t                 owed_q[$];
    int unsigned                 errors;
    int unsigned                 words_taken;
    int unsigned                 results_checked;
    int unsigned                 matched_lists;
    int unsigned                 empty_lists;
    int unsigned                 ovf_lists;

    function new();
      radius_sq       = drnm_pkg::CFG_RESET;
      errors          = 0;
      words_taken     = 0;
      results_checked = 0;
      matched_lists   = 0;
      empty_lists     = 0;
      ovf_lists       = 0;
      restart_list();
    endfunction

    function void restart_list();
      best_dsq = drnm_pkg::DIST_MAX;
      best_pos = 0;
      seen_cnt = 0;
      ovf_seen = 1'b0;
    endfunction

    function void set_radius(logic [drnm_pkg::DIST_W-1:0] v);
      radius_sq = v;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // deta^2 + dphi^2 with phi wrapped to the angle width, saturated
    function logic [drnm_pkg::DIST_W-1:0] dist_sq(cand_word_t w);
      longint deta;
      longint dphi;
      longint sum;
      deta = longint'(w.r_eta) - longint'(w.c_eta);
      dphi = longint'(w.r_phi) - longint'(w.c_phi);
      dphi = dphi & ((longint'(1) << ANG_BITS) - 1);
      if (dphi >= (longint'(1) << (ANG_BITS - 1))) dphi = dphi - (longint'(1) << ANG_BITS);
      sum = deta * deta + dphi * dphi;
      if (sum > longint'(drnm_pkg::DIST_MAX)) return drnm_pkg::DIST_MAX;
      return sum[drnm_pkg::DIST_W-1:0];
    endfunction

    function void note_input(cand_word_t w);
      match_word_t                 res;
      logic [drnm_pkg::DIST_W-1:0] d;
      words_taken++;
      if (w.no_cand) begin
        // empty list, any partial list is thrown away
        res.matched  = 1'b0;
        res.idx      = drnm_pkg::NO_MATCH;
        res.best_dsq = drnm_pkg::DIST_MAX;
        res.ovf      = 1'b0;
        owed_q.push_back(res);
        empty_lists++;
        restart_list();
        return;
      end
      if (seen_cnt < MAX_CAND) begin
        d = dist_sq(w);
        // first candidate always takes the minimum, then strict less-than
        if (seen_cnt == 0 || d < best_dsq) begin
          best_dsq = d;
          best_pos = seen_cnt;
        end
        seen_cnt++;
      end else begin
        ovf_seen = 1'b1;
      end
      if (!w.list_end) return;
      res.matched  = (best_dsq < radius_sq);
      res.idx      = res.matched ? drnm_pkg::IDX_W'(best_pos) : drnm_pkg::NO_MATCH;
      res.best_dsq = best_dsq;
      res.ovf      = ovf_seen;
      owed_q.push_back(res);
      if (res.matched) matched_lists++;
      if (res.ovf) ovf_lists++;
      restart_list();
    endfunction

    function void check_result(match_word_t got);
      match_word_t exp_w;
      if (owed_q.size() == 0) begin
        $error("unexpected result word: matched %0d match_index %0d best_dist_squared %0d",
               got.matched, got.idx, got.best_dsq);
        errors++;
        return;
      end
      exp_w = owed_q.pop_front();
      results_checked++;
      if (got.matched !== exp_w.matched) begin
        $error("matched: expected %0d, actual %0d", exp_w.matched, got.matched);
        errors++;
      end
      if (got.idx !== exp_w.idx) begin
        $error("match_index: expected %0d, actual %0d", exp_w.idx, got.idx);
        errors++;
      end
      if (got.best_dsq !== exp_w.best_dsq) begin
        $error("best_dist_squared: expected %0d, actual %0d", exp_w.best_dsq, got.best_dsq);
        errors++;
      end
      if (got.ovf !== exp_w.ovf) begin
        $error("overflow: expected %0d, actual %0d", exp_w.ovf, got.ovf);
        errors++;
      end
    endfunction
  endclass

  logic                              clk;
  logic                              rst_n;
  logic                              cfg_we;
  logic [drnm_pkg::DIST_W-1:0]       cfg_wdata;
  logic                              in_valid;
  logic                              in_ready;
  logic signed [drnm_pkg::ETA_W-1:0] in_ref_eta;
  logic signed [drnm_pkg::PHI_W-1:0] in_ref_phi;
  logic signed [drnm_pkg::ETA_W-1:0] in_cand_eta;
  logic signed [drnm_pkg::PHI_W-1:0] in_cand_phi;
  logic                              in_list_end;
  logic                              in_no_candidates;
  logic                              out_valid;
  logic                              out_ready;
  logic                              out_matched;
  logic signed [drnm_pkg::IDX_W-1:0] out_match_index;
  logic [drnm_pkg::DIST_W-1:0]       out_best_dist_squared;
  logic                              out_overflow;

  match_scoreboard sb;
  bit              tx_bursty;     // sender idles between bursts in this phase
  int              burst_left;
  bit              rx_hold_req;   // asks the receiver for one long hold-off
  int              stall_cycles;
  int              radius_writes;

  delta_r_nearest_match u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_ref_eta            (in_ref_eta),
    .in_ref_phi            (in_ref_phi),
    .in_cand_eta           (in_cand_eta),
    .in_cand_phi           (in_cand_phi),
    .in_list_end           (in_list_end),
    .in_no_candidates      (in_no_candidates),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_matched           (out_matched),
    .out_match_index       (out_match_index),
    .out_best_dist_squared (out_best_dist_squared),
    .out_overflow          (out_overflow)
  );

  // 20 ns clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // both handshakes are sampled at the edge, before any nba of this step lands
  always @(posedge clk) begin : monitor
    cand_word_t  cw;
    match_word_t mw;
    if (rst_n) begin
      if (in_valid && in_ready === 1'b1) begin
        cw.r_eta    = in_ref_eta;
        cw.r_phi    = in_ref_phi;
        cw.c_eta    = in_cand_eta;
        cw.c_phi    = in_cand_phi;
        cw.list_end = in_list_end;
        cw.no_cand  = in_no_candidates;
        sb.note_input(cw);
      end
      if (out_valid === 1'b1 && out_ready) begin
        mw.matched  = out_matched;
        mw.idx      = out_match_index;
        mw.best_dsq = out_best_dist_squared;
        mw.ovf      = out_overflow;
        sb.check_result(mw);
      end
    end
  end

  // watchdog: too long without any word moving on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $error("no handshake for %0d cycles, %0d result words still owed",
             STALL_LIMIT, sb.pending());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // receiver: random segments of back-pressure, plus one long hold-off on request
  initial begin : receiver
    rx_mode_t rx_mode;
    int       seg_left;
    int       tick;
    rx_mode  = RX_FREE;
    seg_left = 0;
    tick     = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        if (seg_left == 0) begin
          rx_mode  = rx_mode_t'($urandom_range(RX_FREE, RX_BLOCKED));
          seg_left = $urandom_range(1, 64);
        end
        seg_left--;
        tick++;
        case (rx_mode)
          RX_FREE:     out_ready <= 1'b1;
          RX_HALF:     out_ready <= 1'($urandom_range(0, 1));
          RX_SPARSE:   out_ready <= ($urandom_range(0, 3) == 0);
          RX_PERIODIC: out_ready <= (tick % 3 == 0);
          default:     out_ready <= 1'b0;
        endcase
      end
    end
  end

  function automatic cand_word_t mk_word(int r_eta, int r_phi, int c_eta, int c_phi,
                                         int last, int empty);
    cand_word_t w;
    w.r_eta    = drnm_pkg::ETA_W'(r_eta);
    w.r_phi    = drnm_pkg::PHI_W'(r_phi);
    w.c_eta    = drnm_pkg::ETA_W'(c_eta);
    w.c_phi    = drnm_pkg::PHI_W'(c_phi);
    w.list_end = (last != 0);
    w.no_cand  = (empty != 0);
    return w;
  endfunction

  // drop valid and leave the input idle
  task automatic idle_input(int n);
    if (n == 0) return;
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // offer one word and wait for it to be taken; valid stays up for a following word
  task automatic offer(cand_word_t w);
    if (burst_left == 0) begin
      if (tx_bursty) idle_input($urandom_range(0, 6));
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid         <= 1'b1;
    in_ref_eta       <= w.r_eta;
    in_ref_phi       <= w.r_phi;
    in_cand_eta      <= w.c_eta;
    in_cand_phi      <= w.c_phi;
    in_list_end      <= w.list_end;
    in_no_candidates <= w.no_cand;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
  endtask

  // sender pauses until every owed result is in, then lets the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_radius(logic [drnm_pkg::DIST_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_radius(v);
    radius_writes++;
  endtask

  task automatic run_directed();
    // reset radius 522^2: exactly on it misses, just inside matches
    offer(mk_word(0, 0, 522, 0, 1, 0));
    offer(mk_word(0, 0, 521, 32, 1, 0));
    drain();
    write_radius(drnm_pkg::DIST_W'(101));
    // empty list with extreme fields and list_end set, all ignored
    offer(mk_word(8191, 4095, -8192, -4096, 1, 1));
    // 100 is inside, 101 sits on the radius and misses
    offer(mk_word(100, -50, 90, -50, 1, 0));
    offer(mk_word(100, -50, 90, -49, 1, 0));
    // tie at the start: first one wins
    offer(mk_word(0, 0, 7, 1, 0, 0));
    offer(mk_word(0, 0, 1, 7, 0, 0));
    offer(mk_word(0, 0, -10, -10, 1, 0));
    // tie later in the list
    offer(mk_word(0, 0, 20, 0, 0, 0));
    offer(mk_word(0, 0, 0, 7, 0, 0));
    offer(mk_word(0, 0, 7, 0, 1, 0));
    // phi wrap across +-pi in both directions
    offer(mk_word(-3, 4095, -3, -4096, 1, 0));
    offer(mk_word(5, -4096, 5, 4095, 1, 0));
    // largest eta spans, the first with a phi difference of exactly pi
    offer(mk_word(8191, 0, -8192, -4096, 1, 0));
    offer(mk_word(-8192, 4095, 8191, 4095, 1, 0));
    // partial list dropped by an empty-list word
    offer(mk_word(0, 0, 1, 1, 0, 0));
    offer(mk_word(0, 0, 0, 0, 0, 1));
    offer(mk_word(0, 0, 3, 4, 1, 0));
    offer(mk_word(-1, -1, -1, -1, 0, 1));
    // far first candidate still becomes the minimum
    offer(mk_word(0, 0, 8191, -4096, 0, 0));
    offer(mk_word(0, 0, -8192, 4095, 1, 0));
  endtask

  // one random list; mostly well formed, some empty, overflowing or cut short
  task automatic send_random_list(inout int sent);
    cand_word_t w;
    int         kind;
    int         len;
    int         span;
    int         off;
    kind = $urandom_range(0, 99);
    w.r_eta = drnm_pkg::ETA_W'($urandom());
    w.r_phi = drnm_pkg::PHI_W'($urandom());
    if (kind < 6) begin
      w.c_eta    = drnm_pkg::ETA_W'($urandom());
      w.c_phi    = drnm_pkg::PHI_W'($urandom());
      w.list_end = 1'($urandom_range(0, 1));
      w.no_cand  = 1'b1;
      offer(w);
      sent++;
      return;
    end
    if (kind < 10)      len = $urandom_range(MAX_CAND - 4, MAX_CAND + 6);
    else if (kind < 25) len = $urandom_range(9, 40);
    else                len = $urandom_range(1, 8);
    case ($urandom_range(0, 2))
      0:       span = 3;
      1:       span = 40;
      default: span = 700;
    endcase
    for (int i = 0; i < len; i++) begin
      // rare change of the reference inside a list
      if ($urandom_range(0, 99) == 0) begin
        w.r_eta = drnm_pkg::ETA_W'($urandom());
        w.r_phi = drnm_pkg::PHI_W'($urandom());
      end
      if ($urandom_range(0, 9) < 7) begin
        off     = int'($urandom_range(0, 2 * span)) - span;
        w.c_eta = drnm_pkg::ETA_W'(w.r_eta + off);
        off     = int'($urandom_range(0, 2 * span)) - span;
        w.c_phi = drnm_pkg::PHI_W'(w.r_phi + off);
      end else begin
        w.c_eta = drnm_pkg::ETA_W'($urandom());
        w.c_phi = drnm_pkg::PHI_W'($urandom());
      end
      w.list_end = (i == len - 1);
      w.no_cand  = 1'b0;
      // broken list: cut off by an empty-list word
      if (i > 0 && i < len - 1 && $urandom_range(0, 99) < 3) begin
        w.list_end = 1'($urandom_range(0, 1));
        w.no_cand  = 1'b1;
        offer(w);
        sent++;
        return;
      end
      offer(w);
      sent++;
    end
  endtask

  initial begin : stimulus
    logic [drnm_pkg::DIST_W-1:0] radii [PHASES];
    int                          sent;
    sb               = new();
    tx_bursty        = 1'b1;
    burst_left       = 0;
    rx_hold_req      = 1'b0;
    stall_cycles     = 0;
    radius_writes    = 0;
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    in_valid         <= 1'b0;
    in_ref_eta       <= '0;
    in_ref_phi       <= '0;
    in_cand_eta      <= '0;
    in_cand_phi      <= '0;
    in_list_end      <= 1'b0;
    in_no_candidates <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    // radius settings: none, everything, reset value, tiny and two random ones
    radii[0] = '0;
    radii[1] = drnm_pkg::DIST_MAX;
    radii[2] = drnm_pkg::CFG_RESET;
    radii[3] = drnm_pkg::DIST_W'(1);
    radii[4] = drnm_pkg::DIST_W'($urandom_range(0, 20000));
    radii[5] = drnm_pkg::DIST_W'($urandom_range(20000, 600000));

    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_radius(radii[p]);
      if (p == 1) begin
        // sender keeps pushing while the receiver holds off for a long stretch
        tx_bursty   = 1'b0;
        rx_hold_req = 1'b1;
      end else begin
        tx_bursty = ($urandom_range(0, 3) != 0);
      end
      sent = 0;
      while (sent < PHASE_WORDS) send_random_list(sent);
    end

    drain();
    $display("run: %0d words in, %0d result words checked over %0d radius settings",
             sb.words_taken, sb.results_checked, radius_writes);
    $display("run: %0d lists matched, %0d empty, %0d over capacity",
             sb.matched_lists, sb.empty_lists, sb.ovf_lists);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      if (sb.pending() != 0) $error("%0d result words never arrived", sb.pending());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
